### rtl/core/lbrw_pkg.sv
// shared types and constants for the lidar bright-return window block
// no dependencies; imported by every other file of the block but the two interfaces
`default_nettype none

package lbrw_pkg;

  // input action codes
  typedef enum logic [1:0] {
    ACT_BEAM    = 2'd0,
    ACT_COLLECT = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_e;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NO_TRUTH = 2'd2;

  // result kinds
  localparam logic KIND_NEAREST = 1'b0;
  localparam logic KIND_COLLECT = 1'b1;

  // register indexes on the configuration port
  localparam logic [2:0] REG_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_WINDOW_SIZE = 3'd1;
  localparam logic [2:0] REG_ANGLE_LIMIT = 3'd2;
  localparam logic [2:0] REG_ANGLE_START = 3'd3;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd4;

  // register reset values
  localparam logic [15:0]        RST_THRESHOLD   = 16'd200;
  localparam logic [6:0]         RST_WINDOW_SIZE = 7'd10;
  localparam logic [21:0]        RST_ANGLE_LIMIT = 22'd87266;
  localparam logic signed [23:0] RST_ANGLE_START = -24'sd3141593;
  localparam logic signed [16:0] RST_ANGLE_STEP  = 17'sd1745;

  // beams at or above this index are ignored
  localparam logic [16:0] MAX_BEAMS = 17'd4096;

  typedef struct packed {
    logic [15:0]        bright_floor;
    logic [6:0]         window_size;
    logic [21:0]        angle_limit;
    logic signed [23:0] angle_start;
    logic signed [16:0] angle_step;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic track;
    logic clear;
    logic evict;
    logic push;
    logic div_start;
    logic div_step;
    logic out_load;
    logic out_collect;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       scan_end;
    logic       has_hit;
    logic       forward_hit;
    logic       evict_needed;
    logic       collect_fail;
    logic       div_done;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/lbrw_sample_if.sv
// sample channel interface: valid/ready handshake with beam and request payload
// no dependencies
`default_nettype none

interface lbrw_sample_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] range_mm;
  logic        range_ok;
  logic [15:0] intensity;
  logic [11:0] beam_index;
  logic        scan_end;
  logic [15:0] true_distance_mm;

  modport source (
    output valid, action, range_mm, range_ok, intensity, beam_index, scan_end,
           true_distance_mm,
    input  ready
  );
  modport sink (
    input  valid, action, range_mm, range_ok, intensity, beam_index, scan_end,
           true_distance_mm,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/lbrw_result_if.sv
// result channel interface: valid/ready handshake with nearest/collect payload
// no dependencies
`default_nettype none

interface lbrw_result_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [1:0]         status;
  logic [15:0]        distance_mm;
  logic [15:0]        level;
  logic signed [16:0] error_mm;

  modport source (
    output valid, kind, status, distance_mm, level, error_mm,
    input  ready
  );
  modport sink (
    input  valid, kind, status, distance_mm, level, error_mm,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/lbrw_cfg.sv
// configuration register file behind an apb-style port
// depends on lbrw_pkg
`default_nettype none

module lbrw_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output lbrw_pkg::cfg_t cfg
);
  import lbrw_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bright_floor <= RST_THRESHOLD;
      cfg.window_size  <= RST_WINDOW_SIZE;
      cfg.angle_limit  <= RST_ANGLE_LIMIT;
      cfg.angle_start  <= RST_ANGLE_START;
      cfg.angle_step   <= RST_ANGLE_STEP;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_THRESHOLD:   cfg.bright_floor <= pwdata[15:0];
        REG_WINDOW_SIZE: cfg.window_size  <= pwdata[6:0];
        REG_ANGLE_LIMIT: cfg.angle_limit  <= pwdata[21:0];
        REG_ANGLE_START: cfg.angle_start  <= $signed(pwdata[23:0]);
        REG_ANGLE_STEP:  cfg.angle_step   <= $signed(pwdata[16:0]);
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_index)
      REG_THRESHOLD:   prdata = {16'd0, cfg.bright_floor};
      REG_WINDOW_SIZE: prdata = {25'd0, cfg.window_size};
      REG_ANGLE_LIMIT: prdata = {10'd0, cfg.angle_limit};
      REG_ANGLE_START: prdata = {8'd0, cfg.angle_start};
      REG_ANGLE_STEP:  prdata = {15'd0, cfg.angle_step};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/lbrw_datapath.sv
// datapath: item latch, angle multiply, window memory with running sums,
// scan nearest tracking, shared restoring divider and output register
// depends on lbrw_pkg, lbrw_sample_if, lbrw_result_if
`default_nettype none

module lbrw_datapath #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  lbrw_pkg::cfg_t  cfg,
  input  lbrw_pkg::cmd_t  cmd,
  output lbrw_pkg::stat_t stat,
  lbrw_sample_if.sink     samples,
  lbrw_result_if.source   results
);
  import lbrw_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = 16 + FILL_W;
  localparam int CMP_W  = (FILL_W > 7) ? FILL_W : 7;
  localparam int CNT_W  = $clog2(SUM_W);

  // latched item
  logic [1:0]  action_q;
  logic [15:0] range_q;
  logic        ok_q;
  logic [15:0] inten_q;
  logic [11:0] idx_q;
  logic        last_q;
  logic [15:0] truth_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= samples.action;
      range_q  <= samples.range_mm;
      ok_q     <= samples.range_ok;
      inten_q  <= samples.intensity;
      idx_q    <= samples.beam_index;
      last_q   <= samples.scan_end;
      truth_q  <= samples.true_distance_mm;
    end
  end

  // beam angle: registered product, then offset, magnitude and compare
  logic signed [29:0] product;
  logic signed [30:0] angle;
  logic [30:0]        angle_mag;
  logic               bright;
  logic               forward;

  always_ff @(posedge clk) begin
    product <= $signed({1'b0, idx_q}) * cfg.angle_step;
  end

  always_comb begin
    angle     = {{7{cfg.angle_start[23]}}, cfg.angle_start} + {product[29], product};
    angle_mag = angle[30] ? 31'(-angle) : 31'(angle);
    forward   = angle_mag < {9'd0, cfg.angle_limit};
    bright    = ({5'd0, idx_q} < MAX_BEAMS) && ok_q && (inten_q >= cfg.bright_floor);
  end

  // window state
  logic [31:0]       win_mem [WINDOW_DEPTH];
  logic [31:0]       rd_data;
  logic [PTR_W-1:0]  wr_ptr;
  logic [FILL_W-1:0] fill;
  logic [SUM_W-1:0]  range_sum;
  logic [SUM_W-1:0]  level_sum;
  logic [FILL_W:0]   old_diff;
  logic [PTR_W-1:0]  old_addr;
  logic [CMP_W-1:0]  win_ext;
  logic [CMP_W-1:0]  win_lim;

  // oldest entry address and effective window limit
  always_comb begin
    if ((FILL_W + 1)'(wr_ptr) >= (FILL_W + 1)'(fill)) begin
      old_diff = (FILL_W + 1)'(wr_ptr) - (FILL_W + 1)'(fill);
    end else begin
      old_diff = (FILL_W + 1)'(wr_ptr) + (FILL_W + 1)'(WINDOW_DEPTH) - (FILL_W + 1)'(fill);
    end
    old_addr = old_diff[PTR_W-1:0];
    win_ext  = CMP_W'(cfg.window_size);
    if (win_ext == '0) begin
      win_lim = CMP_W'(1);
    end else if (win_ext > CMP_W'(WINDOW_DEPTH)) begin
      win_lim = CMP_W'(WINDOW_DEPTH);
    end else begin
      win_lim = win_ext;
    end
  end

  // window memory, range in the upper half and level in the lower
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_mem[wr_ptr] <= {range_q, inten_q};
    end
    rd_data <= win_mem[old_addr];
  end

  // pointer, fill and running sums
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      wr_ptr    <= '0;
      fill      <= '0;
      range_sum <= '0;
      level_sum <= '0;
    end else if (cmd.evict) begin
      fill      <= fill - FILL_W'(1);
      range_sum <= range_sum - SUM_W'(rd_data[31:16]);
      level_sum <= level_sum - SUM_W'(rd_data[15:0]);
    end else if (cmd.push) begin
      wr_ptr    <= (wr_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      fill      <= fill + FILL_W'(1);
      range_sum <= range_sum + SUM_W'(range_q);
      level_sum <= level_sum + SUM_W'(inten_q);
    end
  end

  // nearest bright return of the current scan
  logic        has_hit;
  logic [15:0] min_range;
  logic [15:0] min_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_hit   <= 1'b0;
      min_range <= '0;
      min_level <= '0;
    end else if (cmd.track && bright && (!has_hit || range_q < min_range)) begin
      has_hit   <= 1'b1;
      min_range <= range_q;
      min_level <= inten_q;
    end else if (cmd.out_load && !cmd.out_collect) begin
      has_hit <= 1'b0;
    end
  end

  // restoring divider, two lanes sharing the fill count as divisor
  logic [SUM_W-1:0]  quo_range;
  logic [SUM_W-1:0]  quo_level;
  logic [FILL_W-1:0] rem_range;
  logic [FILL_W-1:0] rem_level;
  logic [CNT_W-1:0]  div_cnt;
  logic [FILL_W:0]   sh_range;
  logic [FILL_W:0]   sh_level;
  logic              ge_range;
  logic              ge_level;

  always_comb begin
    sh_range = {rem_range, quo_range[SUM_W-1]};
    sh_level = {rem_level, quo_level[SUM_W-1]};
    ge_range = sh_range >= {1'b0, fill};
    ge_level = sh_level >= {1'b0, fill};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_range <= range_sum;
      quo_level <= level_sum;
      rem_range <= '0;
      rem_level <= '0;
    end else if (cmd.div_step) begin
      rem_range <= ge_range ? FILL_W'(sh_range - {1'b0, fill}) : FILL_W'(sh_range);
      rem_level <= ge_level ? FILL_W'(sh_level - {1'b0, fill}) : FILL_W'(sh_level);
      quo_range <= {quo_range[SUM_W-2:0], ge_range};
      quo_level <= {quo_level[SUM_W-2:0], ge_level};
    end
  end

  // output register
  logic               out_valid;
  logic               out_kind;
  logic [1:0]         out_status;
  logic [15:0]        out_dist;
  logic [15:0]        out_level;
  logic signed [16:0] out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!cmd.out_collect) begin
        out_kind   <= KIND_NEAREST;
        out_status <= ST_OK;
        out_dist   <= min_range;
        out_level  <= min_level;
        out_err    <= '0;
      end else if (fill == '0) begin
        out_kind   <= KIND_COLLECT;
        out_status <= ST_EMPTY;
        out_dist   <= '0;
        out_level  <= '0;
        out_err    <= '0;
      end else if (truth_q == '0) begin
        out_kind   <= KIND_COLLECT;
        out_status <= ST_NO_TRUTH;
        out_dist   <= '0;
        out_level  <= '0;
        out_err    <= '0;
      end else begin
        out_kind   <= KIND_COLLECT;
        out_status <= ST_OK;
        out_dist   <= quo_range[15:0];
        out_level  <= quo_level[15:0];
        out_err    <= $signed({1'b0, truth_q}) - $signed({1'b0, quo_range[15:0]});
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.kind        = out_kind;
  assign results.status      = out_status;
  assign results.distance_mm = out_dist;
  assign results.level       = out_level;
  assign results.error_mm    = out_err;

  // status to the controller
  always_comb begin
    stat.action       = action_q;
    stat.scan_end     = last_q;
    stat.has_hit      = has_hit;
    stat.forward_hit  = bright && forward;
    stat.evict_needed = CMP_W'(fill) >= win_lim;
    stat.collect_fail = (fill == '0) || (truth_q == '0);
    stat.div_done     = div_cnt == CNT_W'(SUM_W - 1);
    stat.out_free     = !out_valid || results.ready;
  end

endmodule

`default_nettype wire

### rtl/core/lbrw_ctrl.sv
// controller state machine: sequences one item at a time through the datapath
// depends on lbrw_pkg
`default_nettype none

module lbrw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lbrw_pkg::stat_t stat,
  output lbrw_pkg::cmd_t  cmd
);
  import lbrw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ANGLE,
    S_EVICT,
    S_PUSH,
    S_SCAN,
    S_DIV,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.action)
          ACT_BEAM: begin
            cmd.track  = 1'b1;
            state_next = S_ANGLE;
          end
          ACT_COLLECT: begin
            if (stat.collect_fail) begin
              state_next = S_RESULT;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          ACT_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ANGLE: begin
        if (!stat.forward_hit) begin
          state_next = S_SCAN;
        end else if (stat.evict_needed) begin
          state_next = S_EVICT;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        state_next = (stat.scan_end && stat.has_hit) ? S_RESULT : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_collect = (stat.action == ACT_COLLECT);
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lidar_bright_return_window_top.sv
// lidar bright-return window top: one item at a time, ready only when idle
// beam sample: decode, angle, then for a bright forward return an eviction at the
// window limit and an insert, and a result load when a scan ends with a hit;
// collect: decode, bit-serial division unless empty or no truth, result load;
// synchronous reset clears control state, fill, sums, scan tracking, result valid
// and config registers; window memory is not cleared and is read only once written
`default_nettype none

module lidar_bright_return_window_top #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  lbrw_sample_if.sink   samples,
  lbrw_result_if.source results,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import lbrw_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign samples.ready = in_ready;

  // configuration registers
  lbrw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencing
  lbrw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // window, tracking and division
  lbrw_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat),
    .samples (samples),
    .results (results)
  );

endmodule

`default_nettype wire

### rtl/core/lbrw_checker.sv
// port-level checks for the lidar bright-return window top, attached by bind
// depends on lbrw_pkg and lidar_bright_return_window_top
`default_nettype none

module lbrw_checker (
  input logic               clk,
  input logic               rst,
  input logic               s_valid,
  input logic               s_ready,
  input logic               r_valid,
  input logic               r_ready,
  input logic               r_kind,
  input logic [1:0]         r_status,
  input logic signed [16:0] r_error_mm
);
  import lbrw_pkg::*;

  // a pending result holds until its transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid)
    else $error("result dropped before transfer");

  // one item at a time: ready drops after each accepted transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ready |=> !s_ready)
    else $error("sample accepted while previous item in flight");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !r_valid)
    else $error("result valid after reset");

  // nearest-return results always carry ok status and zero error
  a_nearest_clean: assert property (@(posedge clk) disable iff (rst)
    r_valid && (r_kind == KIND_NEAREST) |-> (r_status == ST_OK) && (r_error_mm == 17'sd0))
    else $error("nearest result with nonzero status or error");

endmodule

bind lidar_bright_return_window_top lbrw_checker u_lbrw_checker (
  .clk        (clk),
  .rst        (rst),
  .s_valid    (samples.valid),
  .s_ready    (samples.ready),
  .r_valid    (results.valid),
  .r_ready    (results.ready),
  .r_kind     (results.kind),
  .r_status   (results.status),
  .r_error_mm (results.error_mm)
);

`default_nettype wire
